>>> sv/ntcadc_pkg.sv
// ----------------------------------------------------------------------------
// ntcadc_pkg
// Shared constants, curve table and per-segment lookups for the NTC
// count-to-temperature converter.
// ----------------------------------------------------------------------------
package ntcadc_pkg;

    localparam int ADC_BITS     = 10;
    localparam int TABLE_POINTS = 8;
    localparam int SEGMENTS     = TABLE_POINTS - 1;
    localparam int SEG_BITS     = $clog2(SEGMENTS);
    localparam int PT_BITS      = $clog2(TABLE_POINTS);
    localparam int TEMP_BITS    = 12;
    localparam int CFG_IDX_BITS = 2;

    // config register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEMP_MIN = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEMP_MAX = CFG_IDX_BITS'(1);

    // segment arithmetic widths
    localparam int SPAN_BITS    = 8;    // widest count span is 150
    localparam int TSPAN_BITS   = 8;    // widest temperature span is 200
    localparam int PROD_BITS    = 15;   // tspan * delta stays below 2^15
    localparam int RECIP_SHIFT  = 23;   // PROD_BITS + SPAN_BITS, exact floor
    localparam int RECIP_BITS   = 18;
    localparam int QUOT_BITS    = 8;

    localparam logic [ADC_BITS-1:0] SHORT_LIMIT = ADC_BITS'(5);
    localparam logic [ADC_BITS-1:0] OPEN_LIMIT  = ADC_BITS'(1018);

    // descending counts, ascending temperatures (tenths of a degree)
    localparam logic [ADC_BITS-1:0] CURVE_COUNT [TABLE_POINTS] =
        '{960, 900, 820, 710, 580, 430, 300, 210};
    localparam logic signed [TEMP_BITS-1:0] CURVE_TEMP [TABLE_POINTS] =
        '{-100, 0, 200, 400, 600, 800, 1000, 1200};

    // ceil(2^RECIP_SHIFT / span) per segment; R*span - 2^23 < span keeps
    // floor(x*R >> 23) exact for every product below 2^15
    localparam logic [RECIP_BITS-1:0] SEG_RECIP [SEGMENTS] =
        '{139811, 104858, 76261, 64528, 55925, 64528, 93207};

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] base;
        logic [QUOT_BITS-1:0]        quot;
        logic                        shorted;
        logic                        open;
    } t_interp;

    function automatic logic [TSPAN_BITS-1:0] seg_tspan(input logic [SEG_BITS-1:0] seg);
        logic signed [TEMP_BITS-1:0] diff;
        diff = CURVE_TEMP[PT_BITS'(seg) + PT_BITS'(1)] - CURVE_TEMP[PT_BITS'(seg)];
        return diff[TSPAN_BITS-1:0];
    endfunction

endpackage

>>> sv/ntcadc_interp.sv
// ----------------------------------------------------------------------------
// ntcadc_interp
// Three-stage interpolation datapath: segment search, span multiply and
// reciprocal multiply for the truncating division by the segment span.
// ----------------------------------------------------------------------------
module ntcadc_interp (
    input  logic                                i_clk,
    input  ntcadc_pkg::t_stage_en               i_en,
    input  logic [ntcadc_pkg::ADC_BITS-1:0]     i_adc_count,
    output ntcadc_pkg::t_interp                 o_res
);
    import ntcadc_pkg::*;

    // stage 1: fault check, clamp, segment search
    logic [ADC_BITS-1:0]   clamped;
    logic [SEG_BITS-1:0]   seg;
    logic [ADC_BITS-1:0]   delta_full;

    logic [SEG_BITS-1:0]   r1_seg;
    logic [SPAN_BITS-1:0]  r1_delta;
    logic                  r1_short;
    logic                  r1_open;

    always_comb begin
        if (i_adc_count >= CURVE_COUNT[0]) begin
            clamped = CURVE_COUNT[0];
        end else if (i_adc_count <= CURVE_COUNT[TABLE_POINTS-1]) begin
            clamped = CURVE_COUNT[TABLE_POINTS-1];
        end else begin
            clamped = i_adc_count;
        end
        // points 1..last-1 at or above the count push the segment index up
        seg = '0;
        for (int k = 1; k < TABLE_POINTS - 1; k++) begin
            if (CURVE_COUNT[k] >= clamped) begin
                seg = seg + SEG_BITS'(1);
            end
        end
        delta_full = CURVE_COUNT[PT_BITS'(seg)] - clamped;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_seg   <= seg;
            r1_delta <= delta_full[SPAN_BITS-1:0];
            r1_short <= (i_adc_count <= SHORT_LIMIT);
            r1_open  <= (i_adc_count >= OPEN_LIMIT);
        end
    end

    // stage 2: temperature span times delta
    logic [TSPAN_BITS+SPAN_BITS-1:0] prod_full;
    logic [PROD_BITS-1:0]            r2_prod;
    logic [SEG_BITS-1:0]             r2_seg;
    logic                            r2_short;
    logic                            r2_open;

    assign prod_full = {{SPAN_BITS{1'b0}}, seg_tspan(r1_seg)}
                     * {{TSPAN_BITS{1'b0}}, r1_delta};

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_prod  <= prod_full[PROD_BITS-1:0];
            r2_seg   <= r1_seg;
            r2_short <= r1_short;
            r2_open  <= r1_open;
        end
    end

    // stage 3: divide by span via reciprocal
    logic [PROD_BITS+RECIP_BITS-1:0] recip_full;
    logic [QUOT_BITS-1:0]            r3_quot;
    logic [SEG_BITS-1:0]             r3_seg;
    logic                            r3_short;
    logic                            r3_open;

    assign recip_full = {{RECIP_BITS{1'b0}}, r2_prod}
                      * {{PROD_BITS{1'b0}}, SEG_RECIP[r2_seg]};

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_quot  <= recip_full[RECIP_SHIFT +: QUOT_BITS];
            r3_seg   <= r2_seg;
            r3_short <= r2_short;
            r3_open  <= r2_open;
        end
    end

    always_comb begin
        o_res.base    = CURVE_TEMP[PT_BITS'(r3_seg)];
        o_res.quot    = r3_quot;
        o_res.shorted = r3_short;
        o_res.open    = r3_open;
    end

endmodule

>>> sv/ntc_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// NTC divider ADC count to temperature (tenths of a degree) with fault and
// plausibility flags.
// ----------------------------------------------------------------------------
// Usage: one 10-bit count word in, one result word out of the output
// register at the end of the pipeline. Counts at or below 5 report a short,
// at or above 1018 an open sensor; both give temperature 0 and clear
// reading_valid. Other counts are clamped to the 960..210 curve ends and
// linearly interpolated between the eight curve points (quotient
// truncates). reading_valid also drops when the temperature is outside
// [temp_min_x10, temp_max_x10] (reset -100 and 1200; writing min above max
// marks every non-fault reading invalid). The block takes a new word every
// cycle that o_stall is low, one word per clock through the four-register
// pipeline: segment search, span multiply, reciprocal multiply (the exact
// divide by the segment span), then base add and limit compare into the
// output register. Each stage moves whenever the one after it is empty or
// moving, so bubbles collapse under a stall and o_stall rises only when all
// four stages hold words. Config registers are always ready; write them
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // sample input
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [ntcadc_pkg::ADC_BITS-1:0]         i_adc_count,
    // result output
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [ntcadc_pkg::TEMP_BITS-1:0] o_temperature_x10,
    output logic                                    o_reading_valid,
    output logic                                    o_sensor_shorted,
    output logic                                    o_sensor_open,
    // config write
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ntcadc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [ntcadc_pkg::TEMP_BITS-1:0]        i_cfg_data
);
    import ntcadc_pkg::*;

    // ---------------- config registers ----------------
    logic signed [TEMP_BITS-1:0] r_temp_min;
    logic signed [TEMP_BITS-1:0] r_temp_max;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_min <= -TEMP_BITS'(100);
            r_temp_max <= TEMP_BITS'(1200);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TEMP_MIN: r_temp_min <= i_cfg_data;
                CFG_TEMP_MAX: r_temp_max <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // r_vld[0..2]: datapath stages, r_vld[3]: output register
    logic [3:0]  r_vld;
    logic [3:0]  adv;
    t_stage_en   en;

    always_comb begin
        adv[3] = !r_vld[3] || !i_stall;
        adv[2] = !r_vld[2] || adv[3];
        adv[1] = !r_vld[1] || adv[2];
        adv[0] = !r_vld[0] || adv[1];
        en.s1  = adv[0];
        en.s2  = adv[1];
        en.s3  = adv[2];
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // ---------------- datapath stages 1..3 ----------------
    t_interp interp;

    ntcadc_interp u_interp (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_adc_count (i_adc_count),
        .o_res       (interp)
    );

    // ---------------- stage 4: base add, faults, limits ----------------
    logic signed [TEMP_BITS-1:0] n_temp;
    logic                        n_reading_valid;
    logic signed [TEMP_BITS-1:0] lin_temp;
    logic                        fault;

    logic signed [TEMP_BITS-1:0] r_temp;
    logic                        r_reading_valid;
    logic                        r_shorted;
    logic                        r_open;

    always_comb begin
        lin_temp = interp.base
                 + $signed({{(TEMP_BITS-QUOT_BITS){1'b0}}, interp.quot});
        fault    = interp.shorted || interp.open;
        if (fault) begin
            n_temp          = '0;
            n_reading_valid = 1'b0;
        end else begin
            n_temp          = lin_temp;
            n_reading_valid = (lin_temp >= r_temp_min) && (lin_temp <= r_temp_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_temp          <= n_temp;
            r_reading_valid <= n_reading_valid;
            r_shorted       <= interp.shorted;
            r_open          <= interp.open && !interp.shorted;
        end
    end

    assign o_valid           = r_vld[3];
    assign o_temperature_x10 = r_temp;
    assign o_reading_valid   = r_reading_valid;
    assign o_sensor_shorted  = r_shorted;
    assign o_sensor_open     = r_open;

    // ---------------- assertions ----------------
    a_fault_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_sensor_shorted && o_sensor_open))
        else $error("short and open flagged together");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sensor_shorted || o_sensor_open))
            |-> (o_temperature_x10 == '0) && !o_reading_valid)
        else $error("fault word carries temperature or valid");

    a_valid_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reading_valid)
            |-> (o_temperature_x10 >= r_temp_min) && (o_temperature_x10 <= r_temp_max))
        else $error("valid reading outside limits");

    a_curve_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sensor_shorted && !o_sensor_open)
            |-> (o_temperature_x10 >= CURVE_TEMP[0])
             && (o_temperature_x10 <= CURVE_TEMP[TABLE_POINTS-1]))
        else $error("interpolated temperature outside curve");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld == 4'b1111))
        else $error("input stalled with a free pipeline stage");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the NTC count-to-temperature converter word by word. A short
// table of probe counts (fault thresholds, curve ends, curve points) runs
// first. Then random counts run under several limit settings: wide,
// crossed, narrow and single-value limits, plus random ones. Every
// accepted count gets an expected result, typed in or predicted here, and
// it is compared with the result that comes back.
// ----------------------------------------------------------------------------
module testbench;

    import ntcadc_pkg::*;

    // unmapped config register indexes, must be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B  = 2'd3;

    // fault thresholds and thermistor curve (count descending, temp rising)
    localparam int SHORT_COUNT = 5;
    localparam int OPEN_COUNT  = 1018;
    localparam int KNEES       = 8;
    localparam int KNEE_COUNT [KNEES] = '{960, 900, 820, 710, 580, 430, 300, 210};
    localparam int KNEE_TEMP  [KNEES] = '{-100, 0, 200, 400, 600, 800, 1000, 1200};

    localparam int PROBE_COUNT  = 24;
    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 150;
    localparam int TAIL_CYCLES  = 12;       // pipeline is four deep
    localparam int CYCLE_LIMIT  = 60000;

    typedef struct packed {
        logic signed [TEMP_BITS-1:0] temp_x10;
        logic                        reading_ok;
        logic                        shorted;
        logic                        opened;
    } t_reading;

    // one probe: count, whether the answer is typed in, and that answer
    typedef struct packed {
        logic [ADC_BITS-1:0] count;
        logic                typed;
        t_reading            want;
    } t_probe;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [ADC_BITS-1:0]         i_adc_count;
    logic                        o_valid;
    logic                        i_stall;
    logic signed [TEMP_BITS-1:0] o_temperature_x10;
    logic                        o_reading_valid;
    logic                        o_sensor_shorted;
    logic                        o_sensor_open;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]     i_cfg_index;
    logic [TEMP_BITS-1:0]        i_cfg_data;

    // travels with each input word: take the typed answer instead of the
    // predicted one
    logic     from_table;
    t_reading table_want;

    // our copy of the limit registers, updated on each accepted write
    logic signed [TEMP_BITS-1:0] limit_lo;
    logic signed [TEMP_BITS-1:0] limit_hi;

    t_reading pending_readings [$];
    t_probe   probes [PROBE_COUNT];
    int       errors;
    int       cycles;
    bit       calm;         // no idling on either side while set

    ntc_adc_to_temperature i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_adc_count       (i_adc_count),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_temperature_x10 (o_temperature_x10),
        .o_reading_valid   (o_reading_valid),
        .o_sensor_shorted  (o_sensor_shorted),
        .o_sensor_open     (o_sensor_open),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Temperature for one count under the current limits. Fault checks
    // come first; then clamp to the curve ends, else interpolate in the
    // segment that holds the count. A count on a knee lands in the earlier
    // segment at its far end, i.e. the knee's own temperature. The quotient
    // is never negative, so int division truncates as required.
    function automatic t_reading predict_reading(input logic [ADC_BITS-1:0] count);
        t_reading r;
        int       c;
        int       t;
        bit       found;
        r     = '0;
        c     = int'(count);
        t     = 0;
        found = 1'b0;
        if (c <= SHORT_COUNT) begin
            r.shorted = 1'b1;
        end else if (c >= OPEN_COUNT) begin
            r.opened = 1'b1;
        end else begin
            if (c >= KNEE_COUNT[0]) begin
                t = KNEE_TEMP[0];
            end else if (c <= KNEE_COUNT[KNEES-1]) begin
                t = KNEE_TEMP[KNEES-1];
            end else begin
                for (int k = 0; k < KNEES - 1; k++) begin
                    if (!found && c <= KNEE_COUNT[k] && c >= KNEE_COUNT[k+1]) begin
                        found = 1'b1;
                        t = KNEE_TEMP[k] + ((KNEE_TEMP[k+1] - KNEE_TEMP[k])
                            * (KNEE_COUNT[k] - c)) / (KNEE_COUNT[k] - KNEE_COUNT[k+1]);
                    end
                end
            end
            r.temp_x10   = TEMP_BITS'(t);
            // crossed limits (lo > hi) fail one side or the other
            r.reading_ok = !(t < int'(limit_lo) || t > int'(limit_hi));
        end
        return r;
    endfunction

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 15);
    endfunction

    // Mostly counts inside the curve; some near knees, some near the
    // fault thresholds, some anywhere in the 10-bit range.
    function automatic logic [ADC_BITS-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return ADC_BITS'($urandom_range(211, 959));
        else if (roll < 75)
            return ADC_BITS'(KNEE_COUNT[$urandom_range(0, KNEES-1)]
                             + $urandom_range(0, 2) - 1);
        else if (roll < 85)
            return roll[0] ? ADC_BITS'($urandom_range(0, 12))
                           : ADC_BITS'($urandom_range(1011, 1023));
        else
            return ADC_BITS'($urandom);
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Scoreboard, config mirror and run limit, all sampled at the rising
    // edge. Output is popped before the input push, though with a four
    // stage pipe the two never meet in one cycle anyway.
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles hit, %0d results outstanding",
                     $time, CYCLE_LIMIT, pending_readings.size());
            $display("Test completed with failures");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEMP_MIN: limit_lo <= i_cfg_data;
                    CFG_TEMP_MAX: limit_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                got = '{o_temperature_x10, o_reading_valid, o_sensor_shorted, o_sensor_open};
                if (pending_readings.size() == 0) begin
                    $display("%0t: result word with nothing expected, got temp %0d",
                             $time, o_temperature_x10);
                    errors++;
                end else begin
                    want = pending_readings.pop_front();
                    report_field("temperature_x10", want.temp_x10, got.temp_x10);
                    report_field("reading_valid", want.reading_ok, got.reading_ok);
                    report_field("sensor_shorted", want.shorted, got.shorted);
                    report_field("sensor_open", want.opened, got.opened);
                end
            end
            if (i_valid && !o_stall)
                pending_readings.push_back(from_table ? table_want
                                                      : predict_reading(i_adc_count));
        end
    end

    // Receiver side: random stall, changed at the falling edge.
    always @(negedge i_clk)
        i_stall <= idle_roll();

    // Sends one count word. Called at a falling edge; returns at the
    // falling edge after the word was taken, with i_valid still high so
    // back-to-back words need no extra assignment.
    task automatic send_count(input logic [ADC_BITS-1:0] count, input logic typed,
                              input t_reading want);
        while (idle_roll()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_adc_count <= count;
        from_table  <= typed;
        table_want  <= want;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Stop sending and hold off until every outstanding result is back.
    // Always advances at least one falling edge so i_valid is not driven
    // twice in one step.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_readings.size() != 0)
            @(negedge i_clk);
    endtask

    // Writes an unmapped register with junk first (must not disturb
    // anything), then the two limits. Pipeline must be empty.
    task automatic program_limits(input int lo, input int hi);
        logic [CFG_IDX_BITS-1:0] idx [3];
        logic [TEMP_BITS-1:0]    val [3];
        idx[0] = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        val[0] = TEMP_BITS'($urandom);
        idx[1] = CFG_TEMP_MIN;
        val[1] = TEMP_BITS'(lo);
        idx[2] = CFG_TEMP_MAX;
        val[2] = TEMP_BITS'(hi);
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int lo;
        int hi;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_adc_count = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TEMP_MIN;
        i_cfg_data  = '0;
        from_table  = 1'b0;
        table_want  = '0;
        limit_lo    = TEMP_BITS'(-100);     // reset values of the block
        limit_hi    = TEMP_BITS'(1200);
        errors      = 0;
        cycles      = 0;
        calm        = 1'b0;

        // Probes run under the reset limits (-100 .. 1200). Typed rows:
        // faults, clamps past the curve ends, and knees (own temperature).
        probes = '{
            '{10'd0,    1'b1, '{0,    1'b0, 1'b1, 1'b0}},   // short, all zero
            '{10'd5,    1'b1, '{0,    1'b0, 1'b1, 1'b0}},   // short threshold
            '{10'd6,    1'b1, '{1200, 1'b1, 1'b0, 1'b0}},   // first good, clamp low end
            '{10'd150,  1'b1, '{1200, 1'b1, 1'b0, 1'b0}},
            '{10'd210,  1'b1, '{1200, 1'b1, 1'b0, 1'b0}},
            '{10'd211,  1'b0, '0},
            '{10'd300,  1'b1, '{1000, 1'b1, 1'b0, 1'b0}},
            '{10'd341,  1'b0, '0},                          // 01_0101_0101
            '{10'd430,  1'b1, '{800,  1'b1, 1'b0, 1'b0}},
            '{10'd511,  1'b0, '0},
            '{10'd512,  1'b0, '0},
            '{10'd580,  1'b1, '{600,  1'b1, 1'b0, 1'b0}},
            '{10'd682,  1'b0, '0},                          // 10_1010_1010
            '{10'd710,  1'b1, '{400,  1'b1, 1'b0, 1'b0}},
            '{10'd711,  1'b0, '0},
            '{10'd820,  1'b1, '{200,  1'b1, 1'b0, 1'b0}},
            '{10'd865,  1'b0, '0},
            '{10'd900,  1'b1, '{0,    1'b1, 1'b0, 1'b0}},
            '{10'd959,  1'b0, '0},
            '{10'd960,  1'b1, '{-100, 1'b1, 1'b0, 1'b0}},
            '{10'd961,  1'b1, '{-100, 1'b1, 1'b0, 1'b0}},   // clamp high end
            '{10'd1017, 1'b1, '{-100, 1'b1, 1'b0, 1'b0}},   // last good count
            '{10'd1018, 1'b1, '{0,    1'b0, 1'b0, 1'b1}},   // open threshold
            '{10'd1023, 1'b1, '{0,    1'b0, 1'b0, 1'b1}}    // open, all ones
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (probes[k])
            send_count(probes[k].count, probes[k].typed, probes[k].want);

        // Limit phases: widest, crossed (nothing valid), narrow, a single
        // legal value (only count 580 gives 600), then random settings.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lo = -1000; hi = 2000;  end
                1: begin lo = 2000;  hi = -1000; end
                2: begin lo = 300;   hi = 700;   end
                3: begin lo = 600;   hi = 600;   end
                default: begin
                    lo = int'($urandom_range(0, 3000)) - 1000;
                    hi = int'($urandom_range(0, 3000)) - 1000;
                end
            endcase
            drain_results();
            program_limits(lo, hi);
            calm = (p == 4);        // one long stretch at full rate
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == PHASE_WORDS / 2)
                    drain_results();    // sender waits for the pipe to empty
                send_count(pick_count(), 1'b0, '0);
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> ntc_adc_to_temperature.f
sv/ntcadc_pkg.sv
sv/ntcadc_interp.sv
sv/ntc_adc_to_temperature.sv
verif/testbench.sv
